FILE: rtl/usmr_pkg.sv
// Shared types, constants and helper functions for the ultrasonic range scanner.
// No dependencies; every other rtl file uses this package.
`default_nettype none

package usmr_pkg;

    // channel count default and field widths
    localparam int CHANNELS_DEF = 8;
    localparam int TICKS_W      = 16;
    localparam int DIST_W       = 13;
    localparam int NEAR_W       = 8;
    localparam int OUT_CH_W     = 3;

    // apb port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_FAR_LIMIT       = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_COLLISION_LIMIT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_VALUE   = 2'd2;

    // register reset values
    localparam logic [NEAR_W-1:0] FAR_LIMIT_RST       = 8'd250;
    localparam logic [NEAR_W-1:0] COLLISION_LIMIT_RST = 8'd10;
    localparam logic [DIST_W-1:0] TIMEOUT_VALUE_RST   = 13'd5000;

    // input item kinds
    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // side sensor pair
    localparam int PAIR_LOW  = 3;
    localparam int PAIR_HIGH = 6;

    localparam logic [NEAR_W-1:0] NEAR_NONE = 8'hFF;

    // ticks / 116 == (ticks >> 2) / 29, done as a multiply by ceil(2^19 / 29)
    localparam int               DIV_SHIFT = 19;
    localparam logic [14:0]      DIV_MULT  = 15'd18079;
    localparam int               PROD_W    = 29;

    typedef struct packed {
        logic [NEAR_W-1:0] far_limit;
        logic [NEAR_W-1:0] collision_limit;
        logic [DIST_W-1:0] timeout_value;
    } cfg_t;

    function automatic logic [DIST_W-1:0] ticks_to_cm(input logic [TICKS_W-1:0] ticks);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(ticks[TICKS_W-1:2]) * PROD_W'(DIV_MULT);
        return DIST_W'(prod[PROD_W-1:DIV_SHIFT]);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/usmr_if.sv
// Valid/ready channel interfaces for the scanner's input items and results.
// Depends on usmr_pkg for the field widths.
`default_nettype none

interface usmr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [usmr_pkg::TICKS_W-1:0]  echo_ticks;
    logic                          scan_all;
    logic                          maneuver_active;
    logic                          approaching;

    modport source (output valid, mode, echo_ticks, scan_all, maneuver_active, approaching,
                    input ready);
    modport sink   (input valid, mode, echo_ticks, scan_all, maneuver_active, approaching,
                    output ready);
endinterface

interface usmr_out_if;
    logic                          valid;
    logic                          ready;
    logic [usmr_pkg::OUT_CH_W-1:0] next_channel;
    logic [usmr_pkg::OUT_CH_W-1:0] closed_channel;
    logic [usmr_pkg::DIST_W-1:0]   closed_distance;
    logic [usmr_pkg::NEAR_W-1:0]   near_first;
    logic [usmr_pkg::NEAR_W-1:0]   near_second;
    logic                          collision_abort;

    modport source (output valid, next_channel, closed_channel, closed_distance,
                    near_first, near_second, collision_abort,
                    input ready);
    modport sink   (input valid, next_channel, closed_channel, closed_distance,
                    near_first, near_second, collision_abort,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/usmr_cfg.sv
// APB register file: far limit, collision limit and timeout value.
// Depends on usmr_pkg for the register map and cfg_t.
`default_nettype none

module usmr_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [usmr_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [usmr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [usmr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output usmr_pkg::cfg_t                         cfg
);
    import usmr_pkg::*;

    logic [NEAR_W-1:0]    far_limit_reg;
    logic [NEAR_W-1:0]    collision_limit_reg;
    logic [DIST_W-1:0]    timeout_value_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            far_limit_reg       <= FAR_LIMIT_RST;
            collision_limit_reg <= COLLISION_LIMIT_RST;
            timeout_value_reg   <= TIMEOUT_VALUE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FAR_LIMIT:       far_limit_reg       <= pwdata[NEAR_W-1:0];
                REG_COLLISION_LIMIT: collision_limit_reg <= pwdata[NEAR_W-1:0];
                REG_TIMEOUT_VALUE:   timeout_value_reg   <= pwdata[DIST_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FAR_LIMIT:       prdata = APB_DATA_W'(far_limit_reg);
            REG_COLLISION_LIMIT: prdata = APB_DATA_W'(collision_limit_reg);
            REG_TIMEOUT_VALUE:   prdata = APB_DATA_W'(timeout_value_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.far_limit       = far_limit_reg;
    assign cfg.collision_limit = collision_limit_reg;
    assign cfg.timeout_value   = timeout_value_reg;

endmodule

`default_nettype wire

FILE: rtl/usmr_core.sv
// Scanner datapath: input register, range and near tables, channel sequencing
// and the result register. Depends on usmr_pkg and the channel interfaces.
`default_nettype none

module usmr_core #(
    parameter int CHANNELS = usmr_pkg::CHANNELS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire usmr_pkg::cfg_t cfg,
    usmr_in_if.sink          in_ch,
    usmr_out_if.source       out_ch
);
    import usmr_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CW-1:0] PAIR_LO  = CW'(PAIR_LOW % CHANNELS);
    localparam logic [CW-1:0] PAIR_HI  = CW'(PAIR_HIGH % CHANNELS);
    localparam logic [CW-1:0] CH_LAST  = CW'(CHANNELS - 1);
    localparam logic [CW-1:0] CH_ZERO  = CW'(0);
    localparam logic [CW-1:0] CH_ONE   = CW'(1);

    // input register
    logic               in_valid_reg;
    logic               in_mode_reg;
    logic [TICKS_W-1:0] in_ticks_reg;
    logic               in_scan_all_reg;
    logic               in_maneuver_reg;
    logic               in_approach_reg;

    // scanner state
    logic [DIST_W-1:0]  range_reg [CHANNELS];
    logic [NEAR_W-1:0]  near0_reg;
    logic [NEAR_W-1:0]  near1_reg;
    logic [CW-1:0]      channel_reg;
    logic               toggle_reg;
    logic               missing_reg;
    logic               await_end_reg;
    logic               hit_seen_reg;

    // result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [OUT_CH_W-1:0] out_next_ch_reg;
    logic [OUT_CH_W-1:0] out_closed_ch_reg;
    logic [DIST_W-1:0]   out_dist_reg;
    logic [NEAR_W-1:0]   out_near0_reg;
    logic [NEAR_W-1:0]   out_near1_reg;
    logic                out_abort_reg;

    logic               take;
    logic               advance;
    logic               load_out;
    logic [DIST_W-1:0]  echo_cm;
    logic [DIST_W-1:0]  scan_dist;
    logic               is_lo;
    logic               is_hi;
    logic               near_hit;
    logic               coll_hit;
    logic               abort_now;
    logic [NEAR_W-1:0]  near0_upd;
    logic [NEAR_W-1:0]  near1_upd;
    logic               toggle_next;
    logic [CW-1:0]      ch_next;

    // an echo edge never waits on the result register
    assign advance = in_valid_reg &&
                     (in_mode_reg == MODE_EDGE || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign take        = in_ch.valid && in_ch.ready;
    assign load_out    = advance && in_mode_reg == MODE_TICK;

    assign echo_cm   = ticks_to_cm(in_ticks_reg);
    assign scan_dist = missing_reg ? cfg.timeout_value : range_reg[channel_reg];
    assign is_lo     = channel_reg == PAIR_LO;
    assign is_hi     = channel_reg == PAIR_HI;

    assign near_hit  = scan_dist < DIST_W'(cfg.far_limit) && !in_maneuver_reg &&
                       (is_lo || is_hi);
    assign coll_hit  = scan_dist < DIST_W'(cfg.collision_limit) && in_maneuver_reg &&
                       !in_approach_reg;
    assign abort_now = coll_hit && hit_seen_reg;

    always_comb
    begin
        near0_upd = near0_reg;
        near1_upd = near1_reg;
        if (near_hit)
        begin
            if (is_lo)
                near1_upd = scan_dist[NEAR_W-1:0];
            else
                near0_upd = scan_dist[NEAR_W-1:0];
        end
        else
        begin
            if (channel_reg == CH_ZERO)
                near0_upd = NEAR_NONE;
            if (channel_reg == CH_ONE)
                near1_upd = NEAR_NONE;
        end
    end

    assign toggle_next = ~toggle_reg;

    always_comb
    begin
        if (in_scan_all_reg)
            ch_next = (channel_reg == CH_LAST) ? CH_ZERO : CW'(channel_reg + CH_ONE);
        else
            ch_next = toggle_next ? PAIR_HI : PAIR_LO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_mode_reg     <= in_ch.mode;
            in_ticks_reg    <= in_ch.echo_ticks;
            in_scan_all_reg <= in_ch.scan_all;
            in_maneuver_reg <= in_ch.maneuver_active;
            in_approach_reg <= in_ch.approaching;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                range_reg[i] <= '0;
            near0_reg     <= '0;
            near1_reg     <= '0;
            channel_reg   <= '0;
            toggle_reg    <= 1'b0;
            missing_reg   <= 1'b0;
            await_end_reg <= 1'b0;
            hit_seen_reg  <= 1'b0;
        end
        else if (advance)
        begin
            if (in_mode_reg == MODE_EDGE)
            begin
                if (!await_end_reg)
                begin
                    await_end_reg <= 1'b1;
                    missing_reg   <= 1'b0;
                end
                else
                begin
                    range_reg[channel_reg] <= echo_cm;
                    await_end_reg          <= 1'b0;
                end
            end
            else if (abort_now)
            begin
                // second close hit in a manoeuvre: back to reset state
                for (int i = 0; i < CHANNELS; i++)
                    range_reg[i] <= '0;
                near0_reg     <= '0;
                near1_reg     <= '0;
                channel_reg   <= '0;
                toggle_reg    <= 1'b0;
                missing_reg   <= 1'b0;
                await_end_reg <= 1'b0;
                hit_seen_reg  <= 1'b0;
            end
            else
            begin
                if (missing_reg)
                    range_reg[channel_reg] <= cfg.timeout_value;
                near0_reg     <= near0_upd;
                near1_reg     <= near1_upd;
                hit_seen_reg  <= hit_seen_reg || coll_hit;
                channel_reg   <= ch_next;
                if (!in_scan_all_reg)
                    toggle_reg <= toggle_next;
                missing_reg   <= 1'b1;
                await_end_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_next_ch_reg   <= abort_now ? '0 : OUT_CH_W'(ch_next);
            out_closed_ch_reg <= OUT_CH_W'(channel_reg);
            out_dist_reg      <= scan_dist;
            out_near0_reg     <= abort_now ? '0 : near0_upd;
            out_near1_reg     <= abort_now ? '0 : near1_upd;
            out_abort_reg     <= abort_now;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.next_channel    = out_next_ch_reg;
    assign out_ch.closed_channel  = out_closed_ch_reg;
    assign out_ch.closed_distance = out_dist_reg;
    assign out_ch.near_first      = out_near0_reg;
    assign out_ch.near_second     = out_near1_reg;
    assign out_ch.collision_abort = out_abort_reg;

endmodule

`default_nettype wire

FILE: rtl/ultrasonic_mux_range_scanner.sv
// Top level of the multiplexed ultrasonic range scanner.
// Depends on usmr_pkg, usmr_if, usmr_cfg and usmr_core.
//
//  port     | dir  | carries
//  ---------+------+--------------------------------------------------------
//  in_ch    | sink | echo edges and scan ticks with the scan controls
//  out_ch   | src  | one result per scan tick: channels, distance, near, abort
//  apb      | slv  | far_limit @0x0, collision_limit @0x4, timeout_value @0x8
//
// each transaction is held in the input register; a scan tick's result then
// goes to the result register; one transaction per cycle is sustained while
// no result stalls. the single 14x15 multiply of the cm conversion sets the path.
// echo edges give no result and pass even while a result is stalled; a scan
// tick waits in the input register until the result register is free.
// rst_n clears all tables and sequencing state at once; no clearing pass.
`default_nettype none

module ultrasonic_mux_range_scanner #(
    parameter int CHANNELS = usmr_pkg::CHANNELS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    usmr_in_if.sink                              in_ch,
    usmr_out_if.source                           out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [usmr_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [usmr_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [usmr_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import usmr_pkg::*;

    cfg_t cfg;

    usmr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    usmr_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

FILE: rtl/usmr_checker.sv
// Port-level checks for the range scanner, bound to the top level.
// Depends on usmr_pkg for the field widths.
`default_nettype none

module usmr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [usmr_pkg::OUT_CH_W-1:0] next_channel,
    input wire logic [usmr_pkg::DIST_W-1:0]   closed_distance,
    input wire logic [usmr_pkg::NEAR_W-1:0]   near_first,
    input wire logic [usmr_pkg::NEAR_W-1:0]   near_second,
    input wire logic                          collision_abort
);
    import usmr_pkg::*;

    // an abort clears sequencing and the near table
    a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && collision_abort |->
            next_channel == '0 && near_first == '0 && near_second == '0)
        else $error("abort result does not show cleared state");

    // an abort is caused by a distance under an 8-bit limit
    a_abort_distance: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && collision_abort |-> closed_distance < DIST_W'(256))
        else $error("abort with distance above collision range");

    // with the result register empty the input side never stalls
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(closed_distance) &&
            $stable(next_channel) && $stable(collision_abort))
        else $error("stalled result changed");

endmodule

bind ultrasonic_mux_range_scanner usmr_checker u_usmr_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .next_channel    (out_ch.next_channel),
    .closed_distance (out_ch.closed_distance),
    .near_first      (out_ch.near_first),
    .near_second     (out_ch.near_second),
    .collision_abort (out_ch.collision_abort)
);

`default_nettype wire
